[rtl/d2r_pkg.sv]
// ----------------------------------------------------------------------------
// d2r_pkg: shared types, constants and the microprogram
// Holds the control word layout, the symbol table and the read-only
// program that steps the decimal-to-Roman text filter.
// ----------------------------------------------------------------------------
package d2r_pkg;

    localparam int UADDR_W = 6;

    localparam logic [11:0] ROMAN_MAX = 12'd3999;
    localparam logic [11:0] VALUE_SAT = 12'd4000;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_I    = 8'h49;

    // Symbol indexes, greedy order.
    localparam logic [3:0] SYM_M  = 4'd0;
    localparam logic [3:0] SYM_CM = 4'd1;
    localparam logic [3:0] SYM_D  = 4'd2;
    localparam logic [3:0] SYM_CD = 4'd3;
    localparam logic [3:0] SYM_C  = 4'd4;
    localparam logic [3:0] SYM_XC = 4'd5;
    localparam logic [3:0] SYM_L  = 4'd6;
    localparam logic [3:0] SYM_XL = 4'd7;
    localparam logic [3:0] SYM_X  = 4'd8;
    localparam logic [3:0] SYM_IX = 4'd9;
    localparam logic [3:0] SYM_V  = 4'd10;
    localparam logic [3:0] SYM_IV = 4'd11;
    localparam logic [3:0] SYM_I  = 4'd12;

    // Fixed program addresses.
    localparam logic [UADDR_W-1:0] UA_WAIT  = 6'd0;
    localparam logic [UADDR_W-1:0] UA_FIRST = 6'd1;
    localparam logic [UADDR_W-1:0] UA_ECHO  = 6'd33;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_TEST,
        OP_EMIT,
        OP_ECHO
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [3:0]         sym;
        logic [7:0]         letter;
        logic               sub;
        logic [UADDR_W-1:0] nxt;
        logic [UADDR_W-1:0] jmp;
    } t_uword;

    typedef struct packed {
        logic take;       // a delimiter item was accepted this cycle
        logic skip;       // pending value is zero or too large
        logic ge;         // pending value >= value of the current symbol
        logic slot_free;  // output register can load this cycle
    } t_stat;

    function automatic logic [11:0] sym_value(input logic [3:0] sym);
        logic [11:0] v;
        unique case (sym)
            SYM_M:   v = 12'd1000;
            SYM_CM:  v = 12'd900;
            SYM_D:   v = 12'd500;
            SYM_CD:  v = 12'd400;
            SYM_C:   v = 12'd100;
            SYM_XC:  v = 12'd90;
            SYM_L:   v = 12'd50;
            SYM_XL:  v = 12'd40;
            SYM_X:   v = 12'd10;
            SYM_IX:  v = 12'd9;
            SYM_V:   v = 12'd5;
            SYM_IV:  v = 12'd4;
            SYM_I:   v = 12'd1;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic t_uword mk_test(input logic [3:0] sym,
                                       input logic [UADDR_W-1:0] nxt,
                                       input logic [UADDR_W-1:0] jmp);
        t_uword w;
        w.op     = OP_TEST;
        w.sym    = sym;
        w.letter = 8'h00;
        w.sub    = 1'b0;
        w.nxt    = nxt;
        w.jmp    = jmp;
        return w;
    endfunction

    function automatic t_uword mk_emit(input logic [3:0] sym,
                                       input logic [7:0] letter,
                                       input logic sub,
                                       input logic [UADDR_W-1:0] nxt);
        t_uword w;
        w.op     = OP_EMIT;
        w.sym    = sym;
        w.letter = letter;
        w.sub    = sub;
        w.nxt    = nxt;
        w.jmp    = UA_WAIT;
        return w;
    endfunction

    // Each symbol is a block: a test step, then one or two emit steps.
    // The last emit of a block subtracts and loops back to the block's test.
    function automatic t_uword ucode_word(input logic [UADDR_W-1:0] a);
        t_uword w;
        w = '{op: OP_WAIT, sym: SYM_M, letter: 8'h00, sub: 1'b0,
              nxt: UA_FIRST, jmp: UA_ECHO};
        unique case (a)
            6'd0:    ;
            6'd1:    w = mk_test(SYM_M, 6'd2, 6'd3);
            6'd2:    w = mk_emit(SYM_M, CH_M, 1'b1, 6'd1);
            6'd3:    w = mk_test(SYM_CM, 6'd4, 6'd6);
            6'd4:    w = mk_emit(SYM_CM, CH_C, 1'b0, 6'd5);
            6'd5:    w = mk_emit(SYM_CM, CH_M, 1'b1, 6'd3);
            6'd6:    w = mk_test(SYM_D, 6'd7, 6'd8);
            6'd7:    w = mk_emit(SYM_D, CH_D, 1'b1, 6'd6);
            6'd8:    w = mk_test(SYM_CD, 6'd9, 6'd11);
            6'd9:    w = mk_emit(SYM_CD, CH_C, 1'b0, 6'd10);
            6'd10:   w = mk_emit(SYM_CD, CH_D, 1'b1, 6'd8);
            6'd11:   w = mk_test(SYM_C, 6'd12, 6'd13);
            6'd12:   w = mk_emit(SYM_C, CH_C, 1'b1, 6'd11);
            6'd13:   w = mk_test(SYM_XC, 6'd14, 6'd16);
            6'd14:   w = mk_emit(SYM_XC, CH_X, 1'b0, 6'd15);
            6'd15:   w = mk_emit(SYM_XC, CH_C, 1'b1, 6'd13);
            6'd16:   w = mk_test(SYM_L, 6'd17, 6'd18);
            6'd17:   w = mk_emit(SYM_L, CH_L, 1'b1, 6'd16);
            6'd18:   w = mk_test(SYM_XL, 6'd19, 6'd21);
            6'd19:   w = mk_emit(SYM_XL, CH_X, 1'b0, 6'd20);
            6'd20:   w = mk_emit(SYM_XL, CH_L, 1'b1, 6'd18);
            6'd21:   w = mk_test(SYM_X, 6'd22, 6'd23);
            6'd22:   w = mk_emit(SYM_X, CH_X, 1'b1, 6'd21);
            6'd23:   w = mk_test(SYM_IX, 6'd24, 6'd26);
            6'd24:   w = mk_emit(SYM_IX, CH_I, 1'b0, 6'd25);
            6'd25:   w = mk_emit(SYM_IX, CH_X, 1'b1, 6'd23);
            6'd26:   w = mk_test(SYM_V, 6'd27, 6'd28);
            6'd27:   w = mk_emit(SYM_V, CH_V, 1'b1, 6'd26);
            6'd28:   w = mk_test(SYM_IV, 6'd29, 6'd31);
            6'd29:   w = mk_emit(SYM_IV, CH_I, 1'b0, 6'd30);
            6'd30:   w = mk_emit(SYM_IV, CH_V, 1'b1, 6'd28);
            6'd31:   w = mk_test(SYM_I, 6'd32, UA_ECHO);
            6'd32:   w = mk_emit(SYM_I, CH_I, 1'b1, 6'd31);
            6'd33:   w = '{op: OP_ECHO, sym: SYM_I, letter: 8'h00, sub: 1'b0,
                           nxt: UA_WAIT, jmp: UA_WAIT};
            default: ;
        endcase
        return w;
    endfunction

endpackage

[rtl/decimal_to_roman_text_filter_unit.sv]
// ----------------------------------------------------------------------------
// decimal_to_roman_text_filter_unit: decimal-to-Roman text filter
// Rewrites decimal numbers in a byte stream as Roman numerals.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_text_byte) takes one text
// byte per item. Digit items are absorbed without leaving the wait step and
// build a pending value that saturates at 4000; they produce no output.
// A non-digit item starts the microprogram: it emits the pending value as
// Roman letters, then echoes the byte itself with o_last_of_run set. When
// the pending value is above 3999 no letters are sent and the echo carries
// o_too_large. A zero value gives the echo alone.
// Timing: one program step per cycle while the output register can load;
// emit and echo steps hold while it is full. No item is taken until the
// echo step of the current delimiter is done. A zero or too-large value
// goes from the wait step straight to the echo step. Otherwise the program
// runs one test step per symbol, one extra test per symbol use, one step
// per letter and one echo step. The first letter follows the symbol tests
// that fail before the first match.
// Reset (synchronous, active low) clears the pending value, empties the
// output register and returns the step counter to the wait step.
// When the receiver stalls, the current emit or echo step holds until the output
// register frees up; no item is lost and input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module decimal_to_roman_text_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_too_large
);
    import d2r_pkg::*;

    // Control word of the current step, and status for the jump decisions.
    t_uword w_uword;
    t_stat  w_stat;

    d2r_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword)
    );

    d2r_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (w_uword),
        .o_stat        (w_stat),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_too_large   (o_too_large)
    );

endmodule

[rtl/d2r_useq.sv]
// ----------------------------------------------------------------------------
// d2r_useq: microprogram sequencer
// Step counter over the program table with conditional jumps on the
// datapath status.
// ----------------------------------------------------------------------------
module d2r_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  d2r_pkg::t_stat  i_stat,
    output d2r_pkg::t_uword o_uword
);
    import d2r_pkg::*;

    logic [UADDR_W-1:0] r_pc;
    logic [UADDR_W-1:0] n_pc;
    t_uword             w_word;

    assign w_word  = ucode_word(r_pc);
    assign o_uword = w_word;

    always_comb begin
        n_pc = r_pc;
        unique case (w_word.op)
            OP_WAIT: begin
                if (i_stat.take) begin
                    n_pc = i_stat.skip ? w_word.jmp : w_word.nxt;
                end
            end
            OP_TEST: begin
                n_pc = i_stat.ge ? w_word.nxt : w_word.jmp;
            end
            OP_EMIT, OP_ECHO: begin
                if (i_stat.slot_free) begin
                    n_pc = w_word.nxt;
                end
            end
            default: n_pc = UA_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/d2r_dpath.sv]
// ----------------------------------------------------------------------------
// d2r_dpath: value accumulator, compare/subtract unit and output register
// Carries out the control word of the current step.
// ----------------------------------------------------------------------------
module d2r_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  d2r_pkg::t_uword i_uword,
    output d2r_pkg::t_stat  o_stat,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_text_byte,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_too_large
);
    import d2r_pkg::*;

    logic [11:0] r_value;
    logic [7:0]  r_byte;
    logic        r_big;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_big;

    logic        w_accept;
    logic        w_digit;
    logic [15:0] w_scaled;
    logic [11:0] w_symval;
    logic        w_slot_free;
    logic        w_load_emit;
    logic        w_load_echo;

    assign o_in_ready  = (i_uword.op == OP_WAIT);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_digit     = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign w_scaled    = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                       + {12'd0, i_text_byte[3:0]};
    assign w_symval    = sym_value(i_uword.sym);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load_emit = (i_uword.op == OP_EMIT) && w_slot_free;
    assign w_load_echo = (i_uword.op == OP_ECHO) && w_slot_free;

    assign o_stat.take      = w_accept && !w_digit;
    assign o_stat.skip      = (r_value > ROMAN_MAX) || (r_value == 12'd0);
    assign o_stat.ge        = (r_value >= w_symval);
    assign o_stat.slot_free = w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 12'd0;
        end else if (w_accept && w_digit) begin
            r_value <= (w_scaled > {4'd0, VALUE_SAT}) ? VALUE_SAT : w_scaled[11:0];
        end else if (w_load_emit && i_uword.sub) begin
            r_value <= r_value - w_symval;
        end else if (w_load_echo) begin
            r_value <= 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_digit) begin
            r_byte <= i_text_byte;
            r_big  <= (r_value > ROMAN_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_emit || w_load_echo) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_emit) begin
            r_out_byte <= i_uword.letter;
            r_out_last <= 1'b0;
            r_out_big  <= 1'b0;
        end else if (w_load_echo) begin
            r_out_byte <= r_byte;
            r_out_last <= 1'b1;
            r_out_big  <= r_big;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_too_large   = r_out_big;

endmodule

[rtl/d2r_checker.sv]
// ----------------------------------------------------------------------------
// d2r_checker: port-level assertions for the text filter
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module d2r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_text_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run,
    input logic       o_too_large
);
    import d2r_pkg::*;

    logic w_delim;

    assign w_delim = (i_text_byte < CH_ZERO) || (i_text_byte > CH_NINE);

    // A stalled item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_too_large))
        else $error("output item changed while stalled");

    // The output register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Too-large is only flagged on the echoed byte.
    a_big_on_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_large |-> o_last_of_run)
        else $error("too_large on a numeral item");

    // While a numeral waits, the run is not over, so no input is taken.
    a_busy_numeral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("input ready in the middle of a run");

    // A delimiter always leaves the block busy in the cycle after it is taken.
    a_delim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && w_delim |=> !o_in_ready)
        else $error("input ready right after a delimiter");

endmodule

bind decimal_to_roman_text_filter_unit d2r_checker u_d2r_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_text_byte   (i_text_byte),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run),
    .o_too_large   (o_too_large)
);
